// ===== rtl/segment_plane_intersect_top_assert.svh =====
// Assertion macros shared by the segment/plane intersection RTL.
`ifndef SEGMENT_PLANE_INTERSECT_TOP_ASSERT_SVH
`define SEGMENT_PLANE_INTERSECT_TOP_ASSERT_SVH

// Condition must never be true out of reset.
`define SPI_ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("spi assertion failed: never");

// Antecedent implies consequent in the same cycle.
`define SPI_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("spi assertion failed: implication");

`endif

// ===== rtl/spi_pkg.sv =====
// ============================================================================
// spi_pkg
// Types and constants for the segment/plane intersection block.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package spi_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int DIST_W     = PROD_W + 2;
    localparam int DEN_W      = PROD_W + 1;
    localparam int REM_W      = DATA_W + PROD_W + 1;
    localparam int DIV_STAGES = DATA_W;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NORMAL_X     = 2'd0,
        CFG_NORMAL_Y     = 2'd1,
        CFG_NORMAL_Z     = 2'd2,
        CFG_PLANE_OFFSET = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [DATA_W-1:0] normal_x;
        logic signed [DATA_W-1:0] normal_y;
        logic signed [DATA_W-1:0] normal_z;
        logic signed [DATA_W-1:0] plane_offset;
    } t_plane;

    typedef struct packed {
        logic signed [DATA_W-1:0] start_x;
        logic signed [DATA_W-1:0] start_y;
        logic signed [DATA_W-1:0] start_z;
        logic signed [DATA_W-1:0] end_x;
        logic signed [DATA_W-1:0] end_y;
        logic signed [DATA_W-1:0] end_z;
    } t_seg;

    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] point_x;
        logic signed [DATA_W-1:0] point_y;
        logic signed [DATA_W-1:0] point_z;
    } t_result;

    // classified request handed from front to back
    typedef struct packed {
        logic                   hit;
        logic [2:0]             neg;
        logic [2:0][DATA_W-1:0] start;
        logic [2:0][DATA_W-1:0] ad;
        logic [PROD_W-1:0]      m0;
        logic [DEN_W-1:0]       den;
    } t_job;

    // one slot of the divider pipeline
    typedef struct packed {
        logic                   hit;
        logic [2:0]             neg;
        logic [2:0][DATA_W-1:0] start;
        logic [DEN_W-1:0]       den;
        logic [2:0][REM_W-1:0]  rem;
        logic [2:0][DATA_W-1:0] q;
    } t_div;

    typedef struct packed {
        logic push;
        logic full;
    } t_qwr;

endpackage

`default_nettype wire

// ===== rtl/spi_front.sv =====
// ============================================================================
// spi_front
// Plane distances of both end points and hit classification (3 stages).
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module spi_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire spi_pkg::t_plane i_plane,
    input  wire logic            i_push,
    output logic                 o_full,
    input  wire spi_pkg::t_seg   i_seg,
    output spi_pkg::t_qwr        o_qwr,
    input  wire logic            i_q_full,
    output spi_pkg::t_job        o_job
);
    import spi_pkg::*;

    logic en;
    logic r_v1, r_v2, r_v3;

    logic signed [2:0][PROD_W-1:0] r_p0, r_p1;
    logic [2:0][DATA_W-1:0]        r_s1, r_s2, r_s3;
    logic signed [2:0][DATA_W:0]   r_df1, r_df2;
    logic signed [DIST_W-1:0]      r_d0, r_d1;
    logic [2:0]                    r_neg3;
    logic [2:0][DATA_W-1:0]        r_ad3;
    logic [PROD_W-1:0]             r_m0, r_m1;
    logic                          r_hit;

    logic signed [2:0][DATA_W-1:0] s_in, e_in, nrm;
    logic signed [DIST_W-1:0]      n_d0, n_d1, n_nd0, n_nd1;
    logic signed [DATA_W:0]        df_neg;
    logic [2:0][DATA_W-1:0]        n_ad;

    assign en     = !(r_v3 && i_q_full);
    assign o_full = !en;

    assign s_in = {i_seg.start_x, i_seg.start_y, i_seg.start_z};
    assign e_in = {i_seg.end_x, i_seg.end_y, i_seg.end_z};
    assign nrm  = {i_plane.normal_x, i_plane.normal_y, i_plane.normal_z};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_push;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // packed element selects are unsigned, so sign is restored explicitly
    always_comb begin
        n_d0 = DIST_W'($signed(r_p0[0])) + DIST_W'($signed(r_p0[1]))
             + DIST_W'($signed(r_p0[2]))
             + (DIST_W'(i_plane.plane_offset) <<< FRAC_BITS);
        n_d1 = DIST_W'($signed(r_p1[0])) + DIST_W'($signed(r_p1[1]))
             + DIST_W'($signed(r_p1[2]))
             + (DIST_W'(i_plane.plane_offset) <<< FRAC_BITS);
        n_nd0 = -r_d0;
        n_nd1 = -r_d1;
        for (int k = 0; k < 3; k++) begin
            df_neg  = -r_df2[k];
            n_ad[k] = r_df2[k][DATA_W] ? df_neg[DATA_W-1:0] : r_df2[k][DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_p0[k]  <= $signed(nrm[k]) * $signed(s_in[k]);
                r_p1[k]  <= $signed(nrm[k]) * $signed(e_in[k]);
                r_df1[k] <= (DATA_W+1)'($signed(e_in[k]))
                          - (DATA_W+1)'($signed(s_in[k]));
            end
            r_s1  <= s_in;
            r_d0  <= n_d0;
            r_d1  <= n_d1;
            r_s2  <= r_s1;
            r_df2 <= r_df1;
            r_m0  <= r_d0[DIST_W-1] ? n_nd0[PROD_W-1:0] : r_d0[PROD_W-1:0];
            r_m1  <= r_d1[DIST_W-1] ? n_nd1[PROD_W-1:0] : r_d1[PROD_W-1:0];
            // strict crossing: both nonzero, opposite signs
            r_hit <= (r_d0 != '0) && (r_d1 != '0)
                     && (r_d0[DIST_W-1] != r_d1[DIST_W-1]);
            r_s3  <= r_s2;
            r_ad3 <= n_ad;
            for (int k = 0; k < 3; k++) begin
                r_neg3[k] <= r_df2[k][DATA_W];
            end
        end
    end

    assign o_qwr.push = r_v3 && !i_q_full;
    assign o_qwr.full = o_full;

    assign o_job.hit   = r_hit;
    assign o_job.neg   = r_neg3;
    assign o_job.start = r_s3;
    assign o_job.ad    = r_ad3;
    assign o_job.m0    = r_m0;
    assign o_job.den   = {1'b0, r_m0} + {1'b0, r_m1};

endmodule

`default_nettype wire

// ===== rtl/spi_midq.sv =====
// ============================================================================
// spi_midq
// Four-entry queue decoupling the classifier from the divider.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

`include "segment_plane_intersect_top_assert.svh"

module spi_midq (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire spi_pkg::t_qwr i_qwr,
    input  wire spi_pkg::t_job i_job,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_empty,
    output spi_pkg::t_job      o_job
);
    import spi_pkg::*;

    t_job       r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       do_push, do_pop;

    assign o_full  = (r_cnt == 3'd4);
    assign o_empty = (r_cnt == 3'd0);
    assign do_push = i_qwr.push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 2'd1;
            if (do_pop)  r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(do_push) - 3'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_job;
    end

    `SPI_ASSERT_NEVER(a_midq_push_full, i_clk, i_rst_n, i_qwr.push && o_full)
    `SPI_ASSERT_NEVER(a_midq_cnt_range, i_clk, i_rst_n, r_cnt > 3'd4)
    `SPI_ASSERT_IMPL(a_midq_ptr_sync, i_clk, i_rst_n, o_empty || o_full, r_wp == r_rp)

endmodule

`default_nettype wire

// ===== rtl/spi_back.sv =====
// ============================================================================
// spi_back
// Offset products, 32-stage restoring divider, point assembly, result buffer.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

`include "segment_plane_intersect_top_assert.svh"

module spi_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_empty,
    output logic               o_q_pop,
    input  wire spi_pkg::t_job i_job,
    output logic               o_empty,
    input  wire logic          i_pop,
    output spi_pkg::t_result   o_res
);
    import spi_pkg::*;

    logic en;
    logic r_v1, r_v2;
    logic [DIV_STAGES-1:0] r_dv;

    t_job                   r_j1;
    logic [2:0][PROD_W-1:0] r_plo, r_phi;
    t_div                   r_b2;
    t_div                   r_div [DIV_STAGES];
    t_div                   n_div [DIV_STAGES];

    t_result    r_ob [2];
    logic       r_owp, r_orp;
    logic [1:0] r_ocnt;
    logic       ob_full, ob_push, ob_pop;
    t_div       last;
    t_result    n_res;

    assign ob_full = (r_ocnt == 2'd2);
    assign en      = !(r_dv[DIV_STAGES-1] && ob_full);
    assign o_q_pop = en && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_dv <= '0;
        end else if (en) begin
            r_v1 <= !i_q_empty;
            r_v2 <= r_v1;
            r_dv <= {r_dv[DIV_STAGES-2:0], r_v2};
        end
    end

    // |diff| * m0 as two 32x32 partial products
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_j1 <= i_job;
            for (int k = 0; k < 3; k++) begin
                r_plo[k] <= i_job.ad[k] * i_job.m0[DATA_W-1:0];
                r_phi[k] <= i_job.ad[k] * i_job.m0[PROD_W-1:DATA_W];
            end
            r_b2.hit   <= r_j1.hit;
            r_b2.neg   <= r_j1.neg;
            r_b2.start <= r_j1.start;
            r_b2.den   <= r_j1.den;
            r_b2.q     <= '0;
            for (int k = 0; k < 3; k++) begin
                r_b2.rem[k] <= REM_W'(r_plo[k]) + (REM_W'(r_phi[k]) << DATA_W);
            end
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
        t_div             src;
        logic [REM_W-1:0] sh;
        if (j == 0) begin : g_first
            assign src = r_b2;
        end else begin : g_rest
            assign src = r_div[j-1];
        end
        assign sh = REM_W'(src.den) << (DIV_STAGES - 1 - j);
        always_comb begin
            n_div[j] = src;
            for (int k = 0; k < 3; k++) begin
                if (src.rem[k] >= sh) begin
                    n_div[j].rem[k] = src.rem[k] - sh;
                    n_div[j].q[k]   = {src.q[k][DATA_W-2:0], 1'b1};
                end else begin
                    n_div[j].q[k]   = {src.q[k][DATA_W-2:0], 1'b0};
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) r_div[j] <= n_div[j];
        end
    end

    assign last = r_div[DIV_STAGES-1];

    always_comb begin
        n_res     = '0;
        n_res.hit = last.hit;
        if (last.hit) begin
            n_res.point_x = last.neg[2] ? last.start[2] - last.q[2]
                                        : last.start[2] + last.q[2];
            n_res.point_y = last.neg[1] ? last.start[1] - last.q[1]
                                        : last.start[1] + last.q[1];
            n_res.point_z = last.neg[0] ? last.start[0] - last.q[0]
                                        : last.start[0] + last.q[0];
        end
    end

    assign ob_push = r_dv[DIV_STAGES-1] && en;
    assign ob_pop  = i_pop && !o_empty;
    assign o_empty = (r_ocnt == 2'd0);
    assign o_res   = r_ob[r_orp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= 1'b0;
            r_orp  <= 1'b0;
            r_ocnt <= '0;
        end else begin
            if (ob_push) r_owp <= !r_owp;
            if (ob_pop)  r_orp <= !r_orp;
            r_ocnt <= r_ocnt + 2'(ob_push) - 2'(ob_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ob_push) r_ob[r_owp] <= n_res;
    end

    `SPI_ASSERT_NEVER(a_back_ob_overflow, i_clk, i_rst_n, ob_push && ob_full)
    `SPI_ASSERT_IMPL(a_back_miss_zero, i_clk, i_rst_n, !o_empty && !o_res.hit,
        o_res.point_x == '0 && o_res.point_y == '0 && o_res.point_z == '0)

endmodule

`default_nettype wire

// ===== rtl/segment_plane_intersect_top.sv =====
// ============================================================================
// segment_plane_intersect_top
// Segment versus plane crossing test with interpolated intersection point.
// ============================================================================
//
//   channel   ports                                   request moves when
//   -------   -------------------------------------   -----------------------
//   segment   i_push, o_full, i_seg                   i_push && !o_full
//   result    o_empty, i_pop, o_res                   i_pop && !o_empty
//   config    i_cfg_we, i_cfg_idx, i_cfg_wdata        i_cfg_we
//
// One request per cycle sustained while o_full is low. From accept to o_empty
// low a request passes 3 classifier stages, the middle queue, 2 multiply
// stages, 32 restoring divider stages (one bit each) and the result buffer.
// Reset (i_rst_n low, synchronous) clears the plane registers to zero and
// empties every queue. A full result buffer stalls the divider, which backs
// up the four-entry middle queue and then the classifier, raising o_full.
//
`timescale 1ns / 1ps
`default_nettype none

module segment_plane_intersect_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_push,
    output logic                                o_full,
    input  wire spi_pkg::t_seg                  i_seg,
    output logic                                o_empty,
    input  wire logic                           i_pop,
    output spi_pkg::t_result                    o_res,
    input  wire logic                           i_cfg_we,
    input  wire logic [spi_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [spi_pkg::DATA_W-1:0]     i_cfg_wdata
);
    import spi_pkg::*;

    // plane registers
    t_plane r_plane;

    t_qwr qwr;
    t_job job_in, job_out;
    logic q_full, q_empty, q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_NORMAL_X:     r_plane.normal_x     <= i_cfg_wdata;
                CFG_NORMAL_Y:     r_plane.normal_y     <= i_cfg_wdata;
                CFG_NORMAL_Z:     r_plane.normal_z     <= i_cfg_wdata;
                CFG_PLANE_OFFSET: r_plane.plane_offset <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // distances and hit decision
    spi_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_plane  (r_plane),
        .i_push   (i_push),
        .o_full   (o_full),
        .i_seg    (i_seg),
        .o_qwr    (qwr),
        .i_q_full (q_full),
        .o_job    (job_in)
    );

    // decoupling queue
    spi_midq u_midq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qwr   (qwr),
        .i_job   (job_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_job   (job_out)
    );

    // fraction division and point assembly
    spi_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .i_job     (job_out),
        .o_empty   (o_empty),
        .i_pop     (i_pop),
        .o_res     (o_res)
    );

endmodule

`default_nettype wire

// ===== bench/segment_plane_intersect_top_tb.sv =====
// ============================================================================
// segment_plane_intersect_top_tb
// Self-checking bench for the segment/plane crossing block.
// ============================================================================
// Segments are pushed through the input queue with random gaps. Each one is
// also handed to a local predictor, which works out the exact distances and
// the truncated interpolation at full width. Results are popped under random
// back-pressure and compared field by field, in order, against the
// predictions. Plane registers change only while the pipeline is drained.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module segment_plane_intersect_top_tb;
    import spi_pkg::*;

    localparam int PIPE_LAT = 45;          // pipeline latency plus margin

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_push = 1'b0;
    logic            o_full;
    t_seg            i_seg = '0;
    logic            o_empty;
    logic            i_pop = 1'b0;
    t_result         o_res;
    logic            i_cfg_we = 1'b0;
    t_cfg_idx        i_cfg_idx = CFG_NORMAL_X;
    logic [DATA_W-1:0] i_cfg_wdata = '0;

    // local copy of the plane registers
    logic signed [DATA_W-1:0] plane_n[3];
    logic signed [DATA_W-1:0] plane_d;

    t_result crossing_q[$];     // predicted results, oldest first
    int      n_errors = 0;
    int      n_sent = 0;
    int      n_checked = 0;
    int      n_hits = 0;
    bit      stall_calm = 1'b0; // when set, the result side never stalls

    always #2 i_clk = ~i_clk;

    segment_plane_intersect_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .o_full     (o_full),
        .i_seg      (i_seg),
        .o_empty    (o_empty),
        .i_pop      (i_pop),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    // N.p + D at 2*FRAC_BITS fraction bits, exact
    function automatic logic signed [127:0] plane_dist(logic signed [31:0] px,
                                                       logic signed [31:0] py,
                                                       logic signed [31:0] pz);
        logic signed [127:0] acc;
        acc = plane_n[0] * px;
        acc = acc + plane_n[1] * py + plane_n[2] * pz;
        acc = acc + (plane_d <<< FRAC_BITS);
        return acc;
    endfunction

    function automatic t_result crossing_point(t_seg s);
        logic signed [127:0] d0, d1;
        logic [127:0]        m0, m1, den, prod, q;
        logic signed [32:0]  st[3], en[3], diff;
        logic [32:0]         ad, pt;
        logic [31:0]         res[3];
        t_result             r;
        r  = '0;
        d0 = plane_dist(s.start_x, s.start_y, s.start_z);
        d1 = plane_dist(s.end_x, s.end_y, s.end_z);
        // touching, lying in the plane or staying on one side: miss
        if (d0 == 0 || d1 == 0 || ((d0 < 0) == (d1 < 0)))
            return r;
        m0  = d0 < 0 ? -d0 : d0;
        m1  = d1 < 0 ? -d1 : d1;
        den = m0 + m1;
        st[0] = s.start_x; st[1] = s.start_y; st[2] = s.start_z;
        en[0] = s.end_x;   en[1] = s.end_y;   en[2] = s.end_z;
        for (int k = 0; k < 3; k++) begin
            diff   = en[k] - st[k];
            ad     = diff < 0 ? -diff : diff;
            prod   = {95'b0, ad} * m0;
            q      = prod / den;                 // truncates toward zero
            pt     = diff < 0 ? st[k] - q[32:0] : st[k] + q[32:0];
            res[k] = pt[31:0];
        end
        r.hit     = 1'b1;
        r.point_x = res[0];
        r.point_y = res[1];
        r.point_z = res[2];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_NORMAL_X:     plane_n[0] = val;
            CFG_NORMAL_Y:     plane_n[1] = val;
            CFG_NORMAL_Z:     plane_n[2] = val;
            CFG_PLANE_OFFSET: plane_d    = val;
            default: ;
        endcase
    endtask

    // wait for the pipe to drain before touching the plane; called right
    // after the edge that took the last request, so push drops at once
    task automatic drain();
        if (i_push) begin
            i_push <= 1'b0;
        end
        wait (crossing_q.size() == 0);
        repeat (PIPE_LAT) @(posedge i_clk);
    endtask

    task automatic set_plane(logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
                             logic [31:0] d);
        drain();
        write_reg(CFG_NORMAL_X, nx);
        write_reg(CFG_NORMAL_Y, ny);
        write_reg(CFG_NORMAL_Z, nz);
        write_reg(CFG_PLANE_OFFSET, d);
    endtask

    // one segment request; push stays high across back-to-back requests
    task automatic send_seg(t_seg s, bit burst);
        int gap;
        i_push <= 1'b1;
        i_seg  <= s;
        forever begin
            @(negedge i_clk);
            if (!o_full) begin
                crossing_q.push_back(crossing_point(s));
                n_sent++;
                @(posedge i_clk);
                break;
            end
            @(posedge i_clk);
        end
        gap = burst ? 0 : idle_len();
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic t_seg seg_of(logic [31:0] sx, logic [31:0] sy,
                                    logic [31:0] sz, logic [31:0] ex,
                                    logic [31:0] ey, logic [31:0] ez);
        t_seg s;
        s.start_x = sx; s.start_y = sy; s.start_z = sz;
        s.end_x   = ex; s.end_y   = ey; s.end_z   = ez;
        return s;
    endfunction

    function automatic t_seg rand_seg();
        return seg_of($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    endfunction

    // result side: random stalls, with calm stretches
    always @(posedge i_clk) begin
        if (!i_rst_n || stall_calm)
            i_pop <= i_rst_n;
        else if ($urandom_range(0, 99) < 4)
            i_pop <= 1'b0;
        else if (!i_pop && $urandom_range(0, 99) < 85)
            i_pop <= 1'b0;   // low stretches tend to persist
        else
            i_pop <= 1'b1;
    end

    always @(negedge i_clk) begin
        if (i_rst_n && $urandom_range(0, 499) == 0)
            stall_calm <= ~stall_calm;
    end

    // ------------------------------------------------------------------
    // Checker: inputs settle by the falling edge, request moves next rise
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_result want;
        if (i_rst_n && i_pop && !o_empty) begin
            if (crossing_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_res);
                n_errors++;
            end else begin
                want = crossing_q.pop_front();
                n_checked++;
                if (want.hit) n_hits++;
                if (o_res.hit !== want.hit) begin
                    $display("%0t: hit exp %0b got %0b", $time, want.hit, o_res.hit);
                    n_errors++;
                end
                if (o_res.point_x !== want.point_x) begin
                    $display("%0t: point_x exp %h got %h", $time, want.point_x,
                             o_res.point_x);
                    n_errors++;
                end
                if (o_res.point_y !== want.point_y) begin
                    $display("%0t: point_y exp %h got %h", $time, want.point_y,
                             o_res.point_y);
                    n_errors++;
                end
                if (o_res.point_z !== want.point_z) begin
                    $display("%0t: point_z exp %h got %h", $time, want.point_z,
                             o_res.point_z);
                    n_errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // reset plane is all zero: nothing can hit
    task automatic test_reset_plane();
        plane_n[0] = 0; plane_n[1] = 0; plane_n[2] = 0; plane_d = 0;
        send_seg(seg_of(0, 0, 32'hFFFF0000, 0, 0, 32'h00010000), 1'b0);
        send_seg(rand_seg(), 1'b0);
    endtask

    // plane z = 0, then extremes of the normal and the offset, then a zero normal
    task automatic test_directed();
        set_plane(0, 0, 32'h00010000, 0);
        send_seg(seg_of(0, 0, 32'hFFFF0000, 32'h00040000, 32'h00020000,
                        32'h00010000), 1'b0);                        // clean crossing
        send_seg(seg_of(5, 7, 32'h00030000, 9, 11, 32'hFFFD0000), 1'b1); // reverse
        send_seg(seg_of(1, 2, 0, 3, 4, 32'h00050000), 1'b0);         // start touches
        send_seg(seg_of(1, 2, 32'hFFFB0000, 3, 4, 0), 1'b0);         // end touches
        send_seg(seg_of(1, 2, 0, 32'h7FFFFFFF, 4, 0), 1'b0);         // lies in plane
        send_seg(seg_of(1, 2, 3, 4, 5, 6), 1'b0);                    // same side
        send_seg(seg_of(32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                        32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF), 1'b1);
        send_seg(seg_of(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                        32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF), 1'b0);
        send_seg(seg_of(0, 0, 32'hFFFFFFFF, 0, 0, 1), 1'b0);         // tiny crossing
        set_plane(32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF);
        send_seg(seg_of(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                        32'h80000000, 32'h80000000, 32'h80000000), 1'b0);
        send_seg(seg_of(32'h80000000, 32'h80000000, 32'h80000000,
                        32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF), 1'b1);
        for (int i = 0; i < 4; i++) send_seg(rand_seg(), 1'b0);
        set_plane(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000);
        for (int i = 0; i < 4; i++) send_seg(rand_seg(), 1'b1);
        // zero normal with nonzero offset: always a miss
        set_plane(0, 0, 0, 32'h00010000);
        send_seg(rand_seg(), 1'b0);
        send_seg(rand_seg(), 1'b0);
    endtask

    // random planes, random and plane-touching segments
    task automatic test_random_planes();
        logic [31:0] n[3], d, touch;
        bit          burst;
        for (int p = 0; p < 8; p++) begin
            if (p % 2 == 0) begin
                n[0] = $urandom; n[1] = $urandom; n[2] = $urandom; d = $urandom;
                set_plane(n[0], n[1], n[2], d);
            end else begin
                // axis-like plane z = c, so that touching ends are easy to hit
                touch = $urandom_range(0, 255) << 16;
                set_plane(0, 0, 32'h00010000, -touch);
            end
            burst = $urandom_range(0, 3) == 0;
            for (int i = 0; i < 100; i++) begin
                t_seg s;
                s = rand_seg();
                if (p % 2 == 1) begin
                    if ($urandom_range(0, 9) == 0) s.start_z = touch;
                    else if ($urandom_range(0, 9) == 0) s.end_z = touch;
                    else if ($urandom_range(0, 1)) begin
                        // force a crossing with a short random reach
                        s.start_z = touch - $urandom_range(1, 32'h00FFFFFF);
                        s.end_z   = touch + $urandom_range(1, 32'h00FFFFFF);
                    end
                end
                send_seg(s, burst);
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_plane();
        test_directed();
        test_random_planes();
        drain();
        $display("Sent %0d segments over several planes (extremes, zero normal),",
                 n_sent);
        $display("checked %0d results, %0d of them crossings.", n_checked, n_hits);
        if (n_errors == 0 && crossing_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #4000000;
        $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

// ===== segment_plane_intersect_top.f =====
+incdir+rtl
rtl/spi_pkg.sv
rtl/spi_front.sv
rtl/spi_midq.sv
rtl/spi_back.sv
rtl/segment_plane_intersect_top.sv
bench/segment_plane_intersect_top_tb.sv
